// ===== sv/fcull_pkg.sv =====
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared types and constants for the frustum box culling block.
// ----------------------------------------------------------------------------
package fcull_pkg;

  localparam int NUM_PLANES = 6;
  localparam int PL_W       = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int COEF_W     = 32;
  localparam int PROD_W     = 2 * COEF_W;
  localparam int ACC_W      = PROD_W + 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef logic [PL_W-1:0] pl_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] b;
    logic [COEF_W-1:0] c;
    logic [COEF_W-1:0] d;
  } plane_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z,
    AX_CHK
  } axis_t;

endpackage

// ===== sv/fcull_plane_store.sv =====
// ----------------------------------------------------------------------------
// fcull_plane_store
// Clip plane register file: one write port, one read port, cleared by reset.
// ----------------------------------------------------------------------------
module fcull_plane_store (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  fcull_pkg::pl_idx_t wr_idx,
  input  fcull_pkg::plane_t  wr_plane,
  input  fcull_pkg::pl_idx_t rd_idx,
  output fcull_pkg::plane_t  rd_plane
);
  import fcull_pkg::*;

  plane_t planes_r [NUM_PLANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        planes_r[i] <= '0;
      end
    end else if (wr_en) begin
      planes_r[wr_idx] <= wr_plane;
    end
  end

  assign rd_plane = planes_r[rd_idx];

endmodule

// ===== sv/fcull_mac_unit.sv =====
// ----------------------------------------------------------------------------
// fcull_mac_unit
// Shared 32x32 multiplier and wide accumulator. Picks the positive vertex
// coordinate per axis and reports the sign of the plane distance.
// ----------------------------------------------------------------------------
module fcull_mac_unit (
  input  logic                          clk,
  input  fcull_pkg::mac_ctrl_t          ctrl,
  input  logic [fcull_pkg::COEF_W-1:0]  coeff,
  input  logic [fcull_pkg::COEF_W-1:0]  lo,
  input  logic [fcull_pkg::COEF_W-1:0]  hi,
  input  logic [fcull_pkg::COEF_W-1:0]  d,
  output logic                          sum_neg
);
  import fcull_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [COEF_W-1:0] coord;
  logic signed [ACC_W-1:0]  sum;
  logic                     lo_lt_hi;

  // largest a*x over {lo, hi}: larger coordinate for a >= 0, smaller otherwise
  always_comb begin
    lo_lt_hi = $signed(lo) < $signed(hi);
    if (coeff[COEF_W-1]) begin
      coord = lo_lt_hi ? $signed(lo) : $signed(hi);
    end else begin
      coord = lo_lt_hi ? $signed(hi) : $signed(lo);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= $signed(coeff) * coord;
    end
    if (ctrl.acc_load) begin
      acc_r <= {{(ACC_W-COEF_W-16){d[COEF_W-1]}}, d, 16'b0};
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign sum     = acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign sum_neg = sum[ACC_W-1];

endmodule

// ===== sv/frustum_box_cull.sv =====
// ----------------------------------------------------------------------------
// frustum_box_cull
// A test request sweeps the planes in turn on the shared multiplier, through
// the X, Y, Z and check steps for each plane, and then holds its result until
// out_ready. No new request is taken until that result is accepted; loads
// are taken while idle, leave the block idle and give no result.
// Reset: synchronous active-low rst_n clears all planes to zero.
// ----------------------------------------------------------------------------
module frustum_box_cull (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [2:0]  in_plane_index,
  input  logic [31:0] in_plane_a,
  input  logic [31:0] in_plane_b,
  input  logic [31:0] in_plane_c,
  input  logic [31:0] in_plane_d,
  input  logic [31:0] in_min_x,
  input  logic [31:0] in_min_y,
  input  logic [31:0] in_min_z,
  input  logic [31:0] in_max_x,
  input  logic [31:0] in_max_y,
  input  logic [31:0] in_max_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_visible
);
  import fcull_pkg::*;

  state_t  state_r, state_nxt;
  axis_t   ax_r, ax_nxt;
  pl_idx_t pl_r, pl_nxt;
  logic    vis_r, vis_nxt;

  logic [COEF_W-1:0] lo_r [3];
  logic [COEF_W-1:0] hi_r [3];

  logic              in_acc;
  logic              wr_en;
  plane_t            wr_plane;
  plane_t            rd_plane;
  mac_ctrl_t         mac_ctrl;
  logic [COEF_W-1:0] coeff;
  logic [COEF_W-1:0] lo_sel;
  logic [COEF_W-1:0] hi_sel;
  logic              sum_neg;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state_r == ST_DONE);
  assign out_visible = vis_r;

  assign wr_en    = in_acc && (in_opcode == OP_LOAD) && (int'(in_plane_index) < NUM_PLANES);
  assign wr_plane = '{a: in_plane_a, b: in_plane_b, c: in_plane_c, d: in_plane_d};

  fcull_plane_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_idx   (PL_W'(in_plane_index)),
    .wr_plane (wr_plane),
    .rd_idx   (pl_r),
    .rd_plane (rd_plane)
  );

  fcull_mac_unit u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .coeff   (coeff),
    .lo      (lo_sel),
    .hi      (hi_sel),
    .d       (rd_plane.d),
    .sum_neg (sum_neg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ax_r    <= AX_X;
      pl_r    <= '0;
      vis_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
      pl_r    <= pl_nxt;
      vis_r   <= vis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_opcode == OP_TEST)) begin
      lo_r[0] <= in_min_x;
      lo_r[1] <= in_min_y;
      lo_r[2] <= in_min_z;
      hi_r[0] <= in_max_x;
      hi_r[1] <= in_max_y;
      hi_r[2] <= in_max_z;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    pl_nxt    = pl_r;
    vis_nxt   = vis_r;
    mac_ctrl  = '0;
    coeff     = rd_plane.a;
    lo_sel    = lo_r[0];
    hi_sel    = hi_r[0];
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_opcode == OP_TEST)) begin
          state_nxt = ST_RUN;
          ax_nxt    = AX_X;
          pl_nxt    = '0;
          vis_nxt   = 1'b1;
        end
      end
      ST_RUN: begin
        case (ax_r)
          AX_X: begin
            mac_ctrl = '{mul_en: 1'b1, acc_load: 1'b1, acc_add: 1'b0};
            ax_nxt   = AX_Y;
          end
          AX_Y: begin
            mac_ctrl = '{mul_en: 1'b1, acc_load: 1'b0, acc_add: 1'b1};
            coeff    = rd_plane.b;
            lo_sel   = lo_r[1];
            hi_sel   = hi_r[1];
            ax_nxt   = AX_Z;
          end
          AX_Z: begin
            mac_ctrl = '{mul_en: 1'b1, acc_load: 1'b0, acc_add: 1'b1};
            coeff    = rd_plane.c;
            lo_sel   = lo_r[2];
            hi_sel   = hi_r[2];
            ax_nxt   = AX_CHK;
          end
          AX_CHK: begin
            vis_nxt = vis_r && !sum_neg;
            ax_nxt  = AX_X;
            if (pl_r == PL_W'(NUM_PLANES - 1)) begin
              state_nxt = ST_DONE;
            end else begin
              pl_nxt = pl_r + 1'b1;
            end
          end
          default: ax_nxt = AX_X;
        endcase
      end
      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_test: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_opcode == OP_TEST)) |=> (!in_ready && !out_valid))
    else $error("test request did not start plane sweep");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && ax_r == AX_CHK && pl_r == PL_W'(NUM_PLANES - 1)) |=> out_valid)
    else $error("result not raised after last plane");

  a_vis_rise_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vis_r) |-> $past(in_acc))
    else $error("visible flag set outside request acceptance");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_opcode == OP_LOAD)) |=> (in_ready && !out_valid))
    else $error("load request left the idle state");
`endif

endmodule

// ===== sim/frustum_box_cull_tb.sv =====
// ----------------------------------------------------------------------------
// frustum_box_cull_tb
// Testbench for the frustum box culling block. Plane loads and box tests are
// queued up front and driven with valid/ready, with random gaps on both
// sides, a long output hold-off and one pause until the pipe is empty. A
// local copy of the plane table predicts the visible flag of each test
// exactly, at 128-bit width, and every result is checked in order.
// ----------------------------------------------------------------------------
module frustum_box_cull_tb;
  import fcull_pkg::*;

  typedef struct {
    logic        opcode;
    logic [2:0]  idx;
    logic [31:0] a, b, c, d;
    logic [31:0] min_x, min_y, min_z;
    logic [31:0] max_x, max_y, max_z;
    logic        drain;
  } req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = OP_LOAD;
  logic [2:0]  in_plane_index = '0;
  logic [31:0] in_plane_a = '0;
  logic [31:0] in_plane_b = '0;
  logic [31:0] in_plane_c = '0;
  logic [31:0] in_plane_d = '0;
  logic [31:0] in_min_x = '0;
  logic [31:0] in_min_y = '0;
  logic [31:0] in_min_z = '0;
  logic [31:0] in_max_x = '0;
  logic [31:0] in_max_y = '0;
  logic [31:0] in_max_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_visible;

  req_t   pending_q[$];
  logic   visible_q[$];
  req_t   cur_req;
  logic   in_taken = 1'b0;
  plane_t plane_tbl[NUM_PLANES];
  int     err_n = 0;
  int     results_n = 0;
  int     cycle_n = 0;
  int     hold_left = 0;
  logic   hold_done = 1'b0;

  frustum_box_cull dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_plane_index (in_plane_index),
    .in_plane_a     (in_plane_a),
    .in_plane_b     (in_plane_b),
    .in_plane_c     (in_plane_c),
    .in_plane_d     (in_plane_d),
    .in_min_x       (in_min_x),
    .in_min_y       (in_min_y),
    .in_min_z       (in_min_z),
    .in_max_x       (in_max_x),
    .in_max_y       (in_max_y),
    .in_max_z       (in_max_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_visible    (out_visible)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_n, what);
    err_n++;
  endtask

  // exact sign test over all corners of the box, 128-bit sums
  function automatic logic predict_visible(input req_t r);
    logic signed [127:0] wa, wb, wc, wd, wx, wy, wz, acc;
    logic outside;
    int p, k;
    for (p = 0; p < NUM_PLANES; p++) begin
      wa = $signed(plane_tbl[p].a);
      wb = $signed(plane_tbl[p].b);
      wc = $signed(plane_tbl[p].c);
      wd = $signed(plane_tbl[p].d);
      outside = 1'b1;
      for (k = 0; k < 8; k++) begin
        wx = (k & 1) ? $signed(r.max_x) : $signed(r.min_x);
        wy = (k & 2) ? $signed(r.max_y) : $signed(r.min_y);
        wz = (k & 4) ? $signed(r.max_z) : $signed(r.min_z);
        acc = wa * wx + wb * wy + wc * wz + (wd <<< 16);
        if (acc >= 0) outside = 1'b0;
      end
      if (outside) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void apply_request(input req_t r);
    if (r.opcode == OP_LOAD) begin
      if (r.idx < NUM_PLANES) plane_tbl[r.idx] = '{r.a, r.b, r.c, r.d};
    end else begin
      visible_q.push_back(predict_visible(r));
    end
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5, 6: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.opcode = 1'($urandom_range(0, 1));
    r.idx    = 3'($urandom_range(0, 7));
    r.a      = $urandom();
    r.b      = $urandom();
    r.c      = $urandom();
    r.d      = $urandom();
    r.min_x  = $urandom();
    r.min_y  = $urandom();
    r.min_z  = $urandom();
    r.max_x  = $urandom();
    r.max_y  = $urandom();
    r.max_z  = $urandom();
    r.drain  = 1'b0;
    return r;
  endfunction

  task automatic push_load(input logic [2:0] idx,
                           input logic [31:0] a, b, c, d);
    req_t r;
    r = rand_req();
    r.opcode = OP_LOAD;
    r.idx = idx;
    r.a = a;
    r.b = b;
    r.c = c;
    r.d = d;
    pending_q.push_back(r);
  endtask

  task automatic push_test(input logic [31:0] mnx, mny, mnz, mxx, mxy, mxz);
    req_t r;
    r = rand_req();
    r.opcode = OP_TEST;
    r.min_x = mnx;
    r.min_y = mny;
    r.min_z = mnz;
    r.max_x = mxx;
    r.max_y = mxy;
    r.max_z = mxz;
    pending_q.push_back(r);
  endtask

  // request acceptance and prediction
  always @(posedge clk) begin
    cycle_n++;
    if (rst_n && in_valid && in_ready) begin
      apply_request(cur_req);
      in_taken = 1'b1;
    end else begin
      in_taken = 1'b0;
    end
  end

  // input driver
  always @(negedge clk) begin : drv
    req_t r;
    logic noisy;
    noisy = (cycle_n < 3000) || (cycle_n > 9000);
    if (rst_n && !(in_valid && !in_taken)) begin
      if (pending_q.size() != 0 && !(noisy && $urandom_range(0, 99) < 10) &&
          !(pending_q[0].drain && visible_q.size() != 0)) begin
        r = pending_q.pop_front();
        cur_req        <= r;
        in_opcode      <= r.opcode;
        in_plane_index <= r.idx;
        in_plane_a     <= r.a;
        in_plane_b     <= r.b;
        in_plane_c     <= r.c;
        in_plane_d     <= r.d;
        in_min_x       <= r.min_x;
        in_min_y       <= r.min_y;
        in_min_z       <= r.min_z;
        in_max_x       <= r.max_x;
        in_max_y       <= r.max_y;
        in_max_z       <= r.max_z;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side ready, with one long hold-off
  always @(negedge clk) begin : rdy
    logic noisy;
    noisy = (cycle_n < 3000) || (cycle_n > 9000);
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_n >= 150) begin
      hold_done = 1'b1;
      hold_left = 600;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(noisy && $urandom_range(0, 99) < 10);
    end
  end

  // result monitor
  always @(posedge clk) begin : mon
    logic exp_vis;
    if (rst_n && out_valid && out_ready) begin
      results_n++;
      if (visible_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        exp_vis = visible_q.pop_front();
        if (out_visible !== exp_vis)
          report_mismatch($sformatf("visible %b, expected %b", out_visible, exp_vis));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : main
    int n;
    int p;
    int base;
    req_t r;
    foreach (plane_tbl[i]) plane_tbl[i] = '0;

    // planes at reset: nothing rejected
    push_test(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    // negative constant only: every box rejected
    push_load(3'd0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff);
    push_test(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    // out-of-range slots leave the table alone
    push_load(3'd6, 32'h0, 32'h0, 32'h0, 32'h0);
    push_load(3'd7, 32'h0, 32'h0, 32'h0, 32'h0);
    push_test(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_load(3'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_test(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    // x >= 0 half space
    push_load(3'd5, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    push_test(32'hfffb_0000, 32'h8000_0000, 32'h8000_0000,
              32'hffff_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    // inverted boxes: straddling, then wholly negative
    push_test(32'h0005_0000, 32'h0, 32'h0, 32'hfffd_0000, 32'h0, 32'h0);
    push_test(32'hffff_0000, 32'h0, 32'h0, 32'hfff9_0000, 32'h0, 32'h0);
    // corner exactly on the plane is not below it
    push_test(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    // extreme coefficients and corners
    push_load(3'd5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_test(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_test(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_load(3'd5, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_test(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_test(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_load(3'd5, 32'h0, 32'h0, 32'h0, 32'h0);

    // full plane sets followed by tests, with some raw noise
    while (pending_q.size() < 1720) begin
      if ($urandom_range(0, 99) < 80) begin
        base = $urandom_range(0, NUM_PLANES - 1);
        for (p = 0; p < NUM_PLANES; p++) begin
          if ($urandom_range(0, 3) == 0)
            push_load(3'((base + p) % NUM_PLANES), 32'h0, 32'h0, 32'h0, 32'h0);
          else
            push_load(3'((base + p) % NUM_PLANES), rand_coef(), rand_coef(),
                      rand_coef(), rand_coef());
        end
        n = $urandom_range(2, 8);
        repeat (n)
          push_test(rand_coef(), rand_coef(), rand_coef(),
                    rand_coef(), rand_coef(), rand_coef());
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          r = rand_req();
          pending_q.push_back(r);
        end
      end
    end
    pending_q[900].drain = 1'b1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (visible_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (err_n == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
